// ===== sv/id_number_check_digit_validator_defines.svh =====
// Assertion helpers used by the queue RTL. Every check samples on the rising clock
// edge and is switched off while reset is high.
`ifndef ID_NUMBER_CHECK_DIGIT_VALIDATOR_DEFINES_SVH
`define ID_NUMBER_CHECK_DIGIT_VALIDATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDV_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IDV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/idv_pkg.sv =====
package idv_pkg;

   localparam int ID_LEN              = 18;
   localparam int DIGITS_LEN          = 17;
   localparam int POS_SAT             = 19;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int FIELD_W = 7;
   localparam int POS_W   = 5;
   localparam int CSR_W   = 14;

   localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
   localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
   localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2024;

   typedef enum logic [1:0] {
      CSR_TODAY_YEAR,
      CSR_TODAY_MONTH,
      CSR_TODAY_DAY
   } csr_index_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } today_type;

   // Everything the back end needs to judge one complete string.
   typedef struct packed {
      logic               len_ok;
      logic               bad_char;
      logic               check_ok;
      logic               region_zero;
      logic               serial_zero;
      logic [YEAR_W-1:0]  year;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] day;
      logic               year_low_zero;
      logic [1:0]         century_mod4;
   } summary_type;

   function automatic logic [3:0] digit_weight(input logic [POS_W-1:0] pos);
      logic [3:0] w;
      case (pos)
         5'd0:    w = 4'd7;
         5'd1:    w = 4'd9;
         5'd2:    w = 4'd10;
         5'd3:    w = 4'd5;
         5'd4:    w = 4'd8;
         5'd5:    w = 4'd4;
         5'd6:    w = 4'd2;
         5'd7:    w = 4'd1;
         5'd8:    w = 4'd6;
         5'd9:    w = 4'd3;
         5'd10:   w = 4'd7;
         5'd11:   w = 4'd9;
         5'd12:   w = 4'd10;
         5'd13:   w = 4'd5;
         5'd14:   w = 4'd8;
         5'd15:   w = 4'd4;
         5'd16:   w = 4'd2;
         default: w = 4'd0;
      endcase
      return w;
   endfunction

   function automatic logic [7:0] check_char(input logic [3:0] residue);
      logic [7:0] c;
      case (residue)
         4'd0:    c = 8'h31;
         4'd1:    c = 8'h30;
         4'd2:    c = 8'h58;
         4'd3:    c = 8'h39;
         4'd4:    c = 8'h38;
         4'd5:    c = 8'h37;
         4'd6:    c = 8'h36;
         4'd7:    c = 8'h35;
         4'd8:    c = 8'h34;
         4'd9:    c = 8'h33;
         4'd10:   c = 8'h32;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Reduces a value below 128 modulo 11 by four conditional subtractions.
   function automatic logic [3:0] mod11(input logic [6:0] value);
      logic [6:0] v;
      v = value;
      if (v >= 7'd88) v = v - 7'd88;
      if (v >= 7'd44) v = v - 7'd44;
      if (v >= 7'd22) v = v - 7'd22;
      if (v >= 7'd11) v = v - 7'd11;
      return v[3:0];
   endfunction

   function automatic logic [DAY_W-1:0] days_in_month(input logic [FIELD_W-1:0] month,
                                                      input logic leap);
      logic [DAY_W-1:0] n;
      case (month) inside
         7'd4, 7'd6, 7'd9, 7'd11: n = 5'd30;
         7'd2:                    n = leap ? 5'd29 : 5'd28;
         [7'd1:7'd12]:            n = 5'd31;
         default:                 n = 5'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== sv/idv_front.sv =====
module idv_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_char_code,
   input  logic                 req_is_final,
   output logic                 push_valid,
   input  logic                 push_ready,
   output idv_pkg::summary_type push_data
);
   import idv_pkg::*;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [3:0]         residue_ff, residue_in;
   logic               bad_ff, bad_in;
   logic               region_zero_ff, region_zero_in;
   logic               serial_zero_ff, serial_zero_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [FIELD_W-1:0] month_ff, month_in;
   logic [FIELD_W-1:0] day_ff, day_in;
   logic               check_ff, check_in;
   logic               low_zero_ff, low_zero_in;
   logic [1:0]         century_ff, century_in;

   logic               accept;
   logic               is_digit;
   logic [3:0]         digit;
   logic [6:0]         product;
   logic [7:0]         folded_char;

   assign req_ready = push_ready;
   assign accept    = req_valid & req_ready;

   assign is_digit    = (req_char_code >= 8'h30) && (req_char_code <= 8'h39);
   assign digit       = is_digit ? 4'(req_char_code - 8'h30) : 4'd0;
   assign product     = 7'(digit) * 7'(digit_weight(pos_ff));
   assign folded_char = (req_char_code == 8'h78) ? 8'h58 : req_char_code;

   always_comb begin
      pos_in         = pos_ff;
      residue_in     = residue_ff;
      bad_in         = bad_ff;
      region_zero_in = region_zero_ff;
      serial_zero_in = serial_zero_ff;
      year_in        = year_ff;
      month_in       = month_ff;
      day_in         = day_ff;
      check_in       = check_ff;
      low_zero_in    = low_zero_ff;
      century_in     = century_ff;
      if (pos_ff < POS_W'(DIGITS_LEN)) begin
         residue_in = mod11(7'(residue_ff) + product);
         if (!is_digit) begin
            bad_in = 1'b1;
         end
         if (pos_ff < 5'd6 && req_char_code != 8'h30) begin
            region_zero_in = 1'b0;
         end
         if (pos_ff >= 5'd14 && req_char_code != 8'h30) begin
            serial_zero_in = 1'b0;
         end
         if (pos_ff >= 5'd6 && pos_ff < 5'd10) begin
            year_in = (year_ff << 3) + (year_ff << 1) + YEAR_W'(digit);
         end else if (pos_ff >= 5'd10 && pos_ff < 5'd12) begin
            month_in = (month_ff << 3) + (month_ff << 1) + FIELD_W'(digit);
         end else if (pos_ff >= 5'd12 && pos_ff < 5'd14) begin
            day_in = (day_ff << 3) + (day_ff << 1) + FIELD_W'(digit);
         end
         // Leap-year facts are gathered from the decimal digits of the year, so the
         // back end never has to divide the year by 100 or 400.
         if (pos_ff == 5'd6) begin
            century_in = {digit[0], 1'b0};
         end else if (pos_ff == 5'd7) begin
            century_in = century_ff + digit[1:0];
         end else if (pos_ff == 5'd8) begin
            low_zero_in = (digit == 4'd0);
         end else if (pos_ff == 5'd9) begin
            low_zero_in = low_zero_ff & (digit == 4'd0);
         end
      end else if (pos_ff == POS_W'(DIGITS_LEN)) begin
         check_in = (folded_char == check_char(residue_ff));
      end
      if (pos_ff < POS_W'(POS_SAT)) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   assign push_valid              = accept & req_is_final;
   assign push_data.len_ok        = (pos_in == POS_W'(ID_LEN));
   assign push_data.bad_char      = bad_in;
   assign push_data.check_ok      = check_in;
   assign push_data.region_zero   = region_zero_in;
   assign push_data.serial_zero   = serial_zero_in;
   assign push_data.year          = year_in;
   assign push_data.month         = month_in;
   assign push_data.day           = day_in;
   assign push_data.year_low_zero = low_zero_in;
   assign push_data.century_mod4  = century_in;

   always_ff @(posedge clock) begin
      if (reset || (accept && req_is_final)) begin
         pos_ff         <= '0;
         residue_ff     <= '0;
         bad_ff         <= 1'b0;
         region_zero_ff <= 1'b1;
         serial_zero_ff <= 1'b1;
         year_ff        <= '0;
         month_ff       <= '0;
         day_ff         <= '0;
         check_ff       <= 1'b0;
         low_zero_ff    <= 1'b0;
         century_ff     <= '0;
      end else if (accept) begin
         pos_ff         <= pos_in;
         residue_ff     <= residue_in;
         bad_ff         <= bad_in;
         region_zero_ff <= region_zero_in;
         serial_zero_ff <= serial_zero_in;
         year_ff        <= year_in;
         month_ff       <= month_in;
         day_ff         <= day_in;
         check_ff       <= check_in;
         low_zero_ff    <= low_zero_in;
         century_ff     <= century_in;
      end
   end

endmodule

// ===== sv/idv_queue.sv =====
`include "id_number_check_digit_validator_defines.svh"

module idv_queue #(
   parameter int DEPTH = idv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  idv_pkg::summary_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output idv_pkg::summary_type pop_data
);
   import idv_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   summary_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `IDV_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + 1'b1, "missed push")
   `IDV_ASSERT_NEXT(a_count_down, pop && !push, count_ff == $past(count_ff) - 1'b1, "missed pop")
   `IDV_ASSERT_IMPLY(a_ptr_gap, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "pointers apart")

endmodule

// ===== sv/idv_back.sv =====
module idv_back (
   input  logic                 clock,
   input  logic                 reset,
   input  idv_pkg::today_type   today,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  idv_pkg::summary_type pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_id_valid
);
   import idv_pkg::*;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_id_valid_ff, rsp_id_valid_in;
   logic               load;
   logic               leap;
   logic [DAY_W-1:0]   month_days;
   logic               date_real;
   logic               not_future;
   logic [FIELD_W-1:0] today_month_ext;
   logic [FIELD_W-1:0] today_day_ext;

   assign pop_ready = ~rsp_valid_ff | rsp_ready;
   assign load      = pop_valid & pop_ready;

   // A year ending in 00 is a leap year only when its century is a multiple of four.
   assign leap = pop_data.year_low_zero ? (pop_data.century_mod4 == 2'd0)
                                        : (pop_data.year[1:0] == 2'd0);

   assign month_days      = days_in_month(pop_data.month, leap);
   assign today_month_ext = FIELD_W'(today.month);
   assign today_day_ext   = FIELD_W'(today.day);

   assign date_real = (pop_data.year != '0) && (month_days != '0) &&
                      (pop_data.day != '0) && (pop_data.day <= FIELD_W'(month_days));

   always_comb begin
      if (pop_data.year != today.year) begin
         not_future = (pop_data.year < today.year);
      end else if (pop_data.month != today_month_ext) begin
         not_future = (pop_data.month < today_month_ext);
      end else begin
         not_future = (pop_data.day <= today_day_ext);
      end
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_id_valid_in = rsp_id_valid_ff;
      if (load) begin
         rsp_valid_in    = 1'b1;
         rsp_id_valid_in = pop_data.len_ok & ~pop_data.bad_char & pop_data.check_ok &
                           ~pop_data.region_zero & ~pop_data.serial_zero &
                           date_real & not_future;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_id_valid_ff <= rsp_id_valid_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_id_valid = rsp_id_valid_ff;

endmodule

// ===== sv/id_number_check_digit_validator.sv =====
// Checks an 18-character national ID number (ISO 7064 MOD 11-2 check character,
// region and serial not all zero, birth date YYYYMMDD real and not after today).
// Send one ASCII byte per request with req_is_final high on the last byte; one
// response with rsp_id_valid comes for each final byte, and any other length reads
// as invalid. The front end takes one byte every cycle. A final byte lands in a
// queue of QUEUE_DEPTH finished strings; the back end judges the head string
// and registers its response. The front end stalls only when the queue is full.
// The user must set the today date through the csr port only while no string is
// in flight, which the block does not check. Reset sets year 2024, month 1, day 1.
module id_number_check_digit_validator #(
   parameter int QUEUE_DEPTH = idv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_char_code,
   input  logic                       req_is_final,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_id_valid,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [idv_pkg::CSR_W-1:0]  csr_wdata
);
   import idv_pkg::*;

   today_type   today_ff;
   summary_type push_data;
   summary_type pop_data;
   logic        push_valid;
   logic        push_ready;
   logic        pop_valid;
   logic        pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         today_ff.year  <= RESET_YEAR;
         today_ff.month <= RESET_MONTH;
         today_ff.day   <= RESET_DAY;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TODAY_YEAR:  today_ff.year  <= csr_wdata[YEAR_W-1:0];
            CSR_TODAY_MONTH: today_ff.month <= csr_wdata[MONTH_W-1:0];
            CSR_TODAY_DAY:   today_ff.day   <= csr_wdata[DAY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   idv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_is_final  (req_is_final),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   idv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   idv_back u_back (
      .clock        (clock),
      .reset        (reset),
      .today        (today_ff),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_data     (pop_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_id_valid (rsp_id_valid)
   );

endmodule
